// ===== rtl/hkred_pkg.sv =====
// ----------------------------------------------------------------------------
// hkred_pkg
// Shared types, constants and keycode translation for the keyboard report
// edge decoder.
// ----------------------------------------------------------------------------
package hkred_pkg;

	localparam int SLOTS     = 6;
	localparam int EVENTS    = 2 * SLOTS;
	localparam int CODE_W    = 8;
	localparam int KEY_W     = 7;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [CODE_W-1:0] SHIFT_MASK = 8'h22;

	// navigation and control codes
	localparam logic [KEY_W-1:0] KEY_NONE  = 7'd0;
	localparam logic [KEY_W-1:0] KEY_HOME  = 7'd2;
	localparam logic [KEY_W-1:0] KEY_END   = 7'd3;
	localparam logic [KEY_W-1:0] KEY_BKSP  = 7'd8;
	localparam logic [KEY_W-1:0] KEY_TAB   = 7'd9;
	localparam logic [KEY_W-1:0] KEY_NEXT  = 7'd9;
	localparam logic [KEY_W-1:0] KEY_ENTER = 7'd10;
	localparam logic [KEY_W-1:0] KEY_PREV  = 7'd11;
	localparam logic [KEY_W-1:0] KEY_UP    = 7'd17;
	localparam logic [KEY_W-1:0] KEY_DOWN  = 7'd18;
	localparam logic [KEY_W-1:0] KEY_RIGHT = 7'd19;
	localparam logic [KEY_W-1:0] KEY_LEFT  = 7'd20;
	localparam logic [KEY_W-1:0] KEY_ESC   = 7'd27;
	localparam logic [KEY_W-1:0] KEY_DEL   = 7'd127;

	// one classified report: release candidates in slots 0..5, presses in 6..11
	typedef struct packed {
		logic [EVENTS-1:0][CODE_W-1:0] codes;
		logic [EVENTS-1:0]             mask;
		logic                          shift;
	} job_t;

	// HID usage to character or navigation code, zero when unmapped
	function automatic logic [KEY_W-1:0] translate(input logic [CODE_W-1:0] code,
		input logic sh);
		logic [CODE_W-1:0] t;
		logic [KEY_W-1:0]  v;
		t = 8'h00;
		v = KEY_NONE;
		if (code >= 8'h04 && code <= 8'h1D) begin
			t = code - 8'h04 + (sh ? 8'h41 : 8'h61);
			v = t[KEY_W-1:0];
		end else if (code >= 8'h1E && code <= 8'h26) begin
			if (sh) begin
				unique case (code)
					8'h1E: v = 7'h21;
					8'h1F: v = 7'h40;
					8'h20: v = 7'h23;
					8'h21: v = 7'h24;
					8'h22: v = 7'h25;
					8'h23: v = 7'h5E;
					8'h24: v = 7'h26;
					8'h25: v = 7'h2A;
					default: v = 7'h28;
				endcase
			end else begin
				t = code - 8'h1E + 8'h31;
				v = t[KEY_W-1:0];
			end
		end else begin
			unique case (code)
				8'h27: v = sh ? 7'h29 : 7'h30;
				8'h28, 8'h58: v = KEY_ENTER;
				8'h29: v = KEY_ESC;
				8'h2A: v = KEY_BKSP;
				8'h2B: v = KEY_TAB;
				8'h2C: v = 7'h20;
				8'h2D: v = sh ? 7'h5F : 7'h2D;
				8'h2E: v = sh ? 7'h2B : 7'h3D;
				8'h2F: v = sh ? 7'h7B : 7'h5B;
				8'h30: v = sh ? 7'h7D : 7'h5D;
				8'h31: v = sh ? 7'h7C : 7'h5C;
				8'h33: v = sh ? 7'h3A : 7'h3B;
				8'h34: v = sh ? 7'h22 : 7'h27;
				8'h35: v = sh ? 7'h7E : 7'h60;
				8'h36: v = sh ? 7'h3C : 7'h2C;
				8'h37: v = sh ? 7'h3E : 7'h2E;
				8'h38: v = sh ? 7'h3F : 7'h2F;
				8'h4A: v = KEY_HOME;
				8'h4B: v = KEY_PREV;
				8'h4C: v = KEY_DEL;
				8'h4D: v = KEY_END;
				8'h4E: v = KEY_NEXT;
				8'h4F: v = KEY_RIGHT;
				8'h50: v = KEY_LEFT;
				8'h51: v = KEY_DOWN;
				8'h52: v = KEY_UP;
				default: v = KEY_NONE;
			endcase
		end
		return v;
	endfunction

endpackage

// ===== rtl/hkred_front.sv =====
// ----------------------------------------------------------------------------
// hkred_front
// Compares an incoming report with the previous one and builds the mask of
// release and press events that it causes.
// ----------------------------------------------------------------------------
module hkred_front import hkred_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [CODE_W-1:0]             modifiers,
	input  logic [SLOTS-1:0][CODE_W-1:0]  cur,
	output job_t                          job,
	output logic                          has_events
);

	logic [SLOTS-1:0][CODE_W-1:0] prev_q;
	logic [SLOTS-1:0]             rel_absent;
	logic [SLOTS-1:0]             prs_absent;

	// presence checks both ways
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			rel_absent[i] = 1'b1;
			prs_absent[i] = 1'b1;
			for (int j = 0; j < SLOTS; j++) begin
				if (cur[j] == prev_q[i])
					rel_absent[i] = 1'b0;
				if (prev_q[j] == cur[i])
					prs_absent[i] = 1'b0;
			end
		end
	end

	// candidate events; a code with no translation is dropped here
	always_comb begin
		job.shift = |(modifiers & SHIFT_MASK);
		for (int i = 0; i < SLOTS; i++) begin
			job.codes[i]         = prev_q[i];
			job.codes[SLOTS + i] = cur[i];
			job.mask[i]          = rel_absent[i] && (translate(prev_q[i], 1'b0) != KEY_NONE);
			job.mask[SLOTS + i]  = prs_absent[i] && (translate(cur[i], 1'b0) != KEY_NONE);
		end
		has_events = |job.mask;
	end

	// previous report store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (accept) begin
			prev_q <= cur;
		end
	end

endmodule

// ===== rtl/hkred_queue.sv =====
// ----------------------------------------------------------------------------
// hkred_queue
// Short queue of classified reports between the front and back parts.
// ----------------------------------------------------------------------------
module hkred_queue import hkred_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  job_t  wdata,
	input  logic  pop,
	output job_t  rdata,
	output logic  full,
	output logic  nonempty
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("queue read while empty");
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH)) else $error("queue level out of range");

endmodule

// ===== rtl/hkred_back.sv =====
// ----------------------------------------------------------------------------
// hkred_back
// Walks the event mask of one report, lowest slot first, translating one
// code per cycle into the result register while that register is free.
// ----------------------------------------------------------------------------
module hkred_back import hkred_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  job_t              q_data,
	input  logic              q_valid,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output logic [KEY_W-1:0]  key_value,
	output logic              is_press,
	output logic              last_event
);

	logic [EVENTS-1:0][CODE_W-1:0] codes_q;
	logic [EVENTS-1:0]             mask_q;
	logic                          shift_q;
	logic                          out_vld_q;
	logic [KEY_W-1:0]              key_q;
	logic                          press_q;
	logic                          last_q;

	logic              busy;
	logic [EVENTS-1:0] pick;
	logic [EVENTS-1:0] rest;
	logic [CODE_W-1:0] code_sel;
	logic              out_free;
	logic              advance;
	logic              load;

	// next event selection
	always_comb begin
		busy     = |mask_q;
		pick     = mask_q & (~mask_q + 1'b1);
		rest     = mask_q & ~pick;
		code_sel = '0;
		for (int i = 0; i < EVENTS; i++)
			code_sel = code_sel | ({CODE_W{pick[i]}} & codes_q[i]);
		out_free = !out_vld_q || pop;
		advance  = busy && out_free;
		load     = q_valid && (!busy || (advance && (rest == '0)));
	end

	assign q_pop      = load;
	assign empty      = !out_vld_q;
	assign key_value  = key_q;
	assign is_press   = press_q;
	assign last_event = last_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load)
				mask_q <= q_data.mask;
			else if (advance)
				mask_q <= rest;
			if (advance)
				out_vld_q <= 1'b1;
			else if (pop)
				out_vld_q <= 1'b0;
		end
	end

	// payload of the current report and the result register
	always_ff @(posedge clk) begin
		if (load) begin
			codes_q <= q_data.codes;
			shift_q <= q_data.shift;
		end
		if (advance) begin
			key_q   <= translate(code_sel, shift_q);
			press_q <= |pick[EVENTS-1:SLOTS];
			last_q  <= (rest == '0);
		end
	end

	a_pick_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> $onehot(pick)) else $error("event pick not one-hot");
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (rest != '0)) |=> busy) else $error("report events lost");
	a_load_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!busy || (advance && (rest == '0))))
		else $error("report loaded over unfinished one");

endmodule

// ===== rtl/hid_keyboard_report_edge_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// hid_keyboard_report_edge_decoder_unit
// Boot-keyboard report decoder: turns key changes into release and press
// events carrying translated character or navigation codes.
// ----------------------------------------------------------------------------
// Input channel: a report (modifiers, slot_a..slot_f) is taken when push is
// high and full is low. The front compares it with the previous report in
// the same cycle and files a mask of events in a two-entry queue; a report
// that causes no event only updates the previous-report store.
// Result channel: while empty is low the oldest event is on key_value,
// is_press and last_event; pop takes it. last_event marks the final event of
// a report. Releases come first, then presses, each in slot order.
// The first event of a report reaches the outputs through the queue, the
// back part's mask register and the result register.
// Throughput: the back part issues one event per cycle while the result
// register is free, up to twelve events per report; the next report
// follows without a gap. Reports are taken every cycle while the queue has
// room.
// Stalls: with pop low the result register holds and the back part waits;
// the queue fills and full rises. Reset clears the previous-report store to
// zero codes and empties the queue and result register.
// ----------------------------------------------------------------------------
module hid_keyboard_report_edge_decoder_unit import hkred_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [CODE_W-1:0] modifiers,
	input  logic [CODE_W-1:0] slot_a,
	input  logic [CODE_W-1:0] slot_b,
	input  logic [CODE_W-1:0] slot_c,
	input  logic [CODE_W-1:0] slot_d,
	input  logic [CODE_W-1:0] slot_e,
	input  logic [CODE_W-1:0] slot_f,
	output logic              empty,
	input  logic              pop,
	output logic [KEY_W-1:0]  key_value,
	output logic              is_press,
	output logic              last_event
);

	logic                         accept;
	logic [SLOTS-1:0][CODE_W-1:0] cur;
	job_t                         fe_job;
	logic                         fe_has_events;
	job_t                         q_data;
	logic                         q_valid;
	logic                         q_pop;

	assign cur    = {slot_f, slot_e, slot_d, slot_c, slot_b, slot_a};
	assign accept = push && !full;

	// classification of incoming reports
	hkred_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.modifiers  (modifiers),
		.cur        (cur),
		.job        (fe_job),
		.has_events (fe_has_events)
	);

	// decoupling queue
	hkred_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && fe_has_events),
		.wdata    (fe_job),
		.pop      (q_pop),
		.rdata    (q_data),
		.full     (full),
		.nonempty (q_valid)
	);

	// event issue
	hkred_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (q_data),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.key_value  (key_value),
		.is_press   (is_press),
		.last_event (last_event)
	);

endmodule

// ===== bench/hid_keyboard_report_edge_decoder_unit_test.sv =====
// ----------------------------------------------------------------------------
// hid_keyboard_report_edge_decoder_unit_test
// Self-checking bench for the boot-keyboard report edge decoder. Reports are
// fed through the push/full side and key events are taken on the empty/pop
// side, with random idling on both sides. A local model works out the
// release and press events for each accepted report and every event is
// compared with the oldest one waiting.
// ----------------------------------------------------------------------------
module hid_keyboard_report_edge_decoder_unit_test;
	import hkred_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 4;
	localparam int RANDOM_ITEMS = 110;
	localparam int LONG_HOLD_AT = 60;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 30;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [79:0] SHIFTED_DIGITS = "!@#$%^&*()";

	typedef logic [CODE_W-1:0] slot_set_t [SLOTS];

	typedef struct {
		logic [CODE_W-1:0] mods;
		slot_set_t         codes;
		bit                drain;
	} report_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             press;
		logic             last;
	} key_event_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [CODE_W-1:0] modifiers = '0;
	logic [CODE_W-1:0] slot_a = '0;
	logic [CODE_W-1:0] slot_b = '0;
	logic [CODE_W-1:0] slot_c = '0;
	logic [CODE_W-1:0] slot_d = '0;
	logic [CODE_W-1:0] slot_e = '0;
	logic [CODE_W-1:0] slot_f = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [KEY_W-1:0]  key_value;
	logic              is_press;
	logic              last_event;

	report_t    pending_reports[$];
	key_event_t expected_keys[$];
	slot_set_t  held_codes = '{default: '0};
	slot_set_t  gen_codes = '{default: '0};
	report_t    offered_report;
	int         fail_count = 0;
	int         reports_taken = 0;
	int         keys_taken = 0;
	int         send_gap = 0;
	int         take_hold = 0;
	longint     cycle_count = 0;

	hid_keyboard_report_edge_decoder_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.modifiers  (modifiers),
		.slot_a     (slot_a),
		.slot_b     (slot_b),
		.slot_c     (slot_c),
		.slot_d     (slot_d),
		.slot_e     (slot_e),
		.slot_f     (slot_f),
		.empty      (empty),
		.pop        (pop),
		.key_value  (key_value),
		.is_press   (is_press),
		.last_event (last_event)
	);

	// clock
	always #(CLK_PERIOD / 2) clk = ~clk;

	// keycode to character or navigation code, zero when unmapped
	function automatic logic [KEY_W-1:0] hid_to_key(input logic [CODE_W-1:0] code,
		input logic sh);
		logic [7:0] ch;
		int         idx;
		ch = 8'h00;
		idx = 0;
		if (code >= 8'h04 && code <= 8'h1D) begin
			ch = (sh ? 8'h41 : 8'h61) + (code - 8'h04);
		end else if (code >= 8'h1E && code <= 8'h27) begin
			idx = int'(code - 8'h1E);
			if (sh)
				ch = SHIFTED_DIGITS[8 * (9 - idx) +: 8];
			else
				ch = (idx == 9) ? 8'h30 : 8'h31 + 8'(idx);
		end else begin
			case (code)
				8'h28, 8'h58: ch = 8'(KEY_ENTER);
				8'h29: ch = 8'(KEY_ESC);
				8'h2A: ch = 8'(KEY_BKSP);
				8'h2B: ch = 8'(KEY_TAB);
				8'h2C: ch = " ";
				8'h2D: ch = sh ? "_" : "-";
				8'h2E: ch = sh ? "+" : "=";
				8'h2F: ch = sh ? "{" : "[";
				8'h30: ch = sh ? "}" : "]";
				8'h31: ch = sh ? "|" : "\\";
				8'h33: ch = sh ? ":" : ";";
				8'h34: ch = sh ? "\"" : "'";
				8'h35: ch = sh ? "~" : 8'h60;
				8'h36: ch = sh ? "<" : ",";
				8'h37: ch = sh ? ">" : ".";
				8'h38: ch = sh ? "?" : "/";
				8'h4A: ch = 8'(KEY_HOME);
				8'h4B: ch = 8'(KEY_PREV);
				8'h4C: ch = 8'(KEY_DEL);
				8'h4D: ch = 8'(KEY_END);
				8'h4E: ch = 8'(KEY_NEXT);
				8'h4F: ch = 8'(KEY_RIGHT);
				8'h50: ch = 8'(KEY_LEFT);
				8'h51: ch = 8'(KEY_DOWN);
				8'h52: ch = 8'(KEY_UP);
				default: ch = 8'h00;
			endcase
		end
		return ch[KEY_W-1:0];
	endfunction

	function automatic bit holds_code(input slot_set_t s, input logic [CODE_W-1:0] c);
		foreach (s[i])
			if (s[i] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	// work out the key events of one accepted report and update the held codes
	function automatic void predict_key_events(input report_t r);
		key_event_t batch[$];
		key_event_t ev;
		logic       sh;
		sh = (r.mods & SHIFT_MASK) != '0;
		for (int i = 0; i < SLOTS; i++)
			if (!holds_code(r.codes, held_codes[i]) && held_codes[i] > 8'h01 &&
				hid_to_key(held_codes[i], sh) != KEY_NONE) begin
				ev = '{key: hid_to_key(held_codes[i], sh), press: 1'b0, last: 1'b0};
				batch.push_back(ev);
			end
		for (int i = 0; i < SLOTS; i++)
			if (!holds_code(held_codes, r.codes[i]) && r.codes[i] > 8'h01 &&
				hid_to_key(r.codes[i], sh) != KEY_NONE) begin
				ev = '{key: hid_to_key(r.codes[i], sh), press: 1'b1, last: 1'b0};
				batch.push_back(ev);
			end
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i])
			expected_keys.push_back(batch[i]);
		held_codes = r.codes;
	endfunction

	// gap lengths: mostly short, a few long
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic queue_report(input logic [CODE_W-1:0] m, input slot_set_t s,
		input bit drain);
		report_t r;
		r.mods = m;
		r.codes = s;
		r.drain = drain;
		pending_reports.push_back(r);
		gen_codes = s;
	endtask

	// mostly plausible keycodes, some empty slots, some arbitrary bytes
	function automatic logic [CODE_W-1:0] random_code();
		int r;
		r = $urandom_range(0, 19);
		if (r < 4)
			return 8'h00;
		else if (r == 4)
			return 8'h01;
		else if (r < 7)
			return 8'($urandom_range(0, 255));
		else if (r < 9)
			return 8'($urandom_range(8'h4A, 8'h52));
		else if (r == 9)
			return ($urandom_range(0, 1) != 0) ? 8'h58 : 8'h32;
		return 8'($urandom_range(8'h04, 8'h38));
	endfunction

	task automatic queue_random_report();
		slot_set_t         s;
		logic [CODE_W-1:0] m;
		int                kind;
		int                changes;
		s = gen_codes;
		m = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0: m = m & ~SHIFT_MASK;
			1: m = (m & ~SHIFT_MASK) | 8'h02;
			2: m = (m & ~SHIFT_MASK) | 8'h20;
			default: ;
		endcase
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			// typing: a few slots change from the last report
			changes = $urandom_range(1, 3);
			repeat (changes)
				s[$urandom_range(0, SLOTS - 1)] = random_code();
		end else if (kind < 75) begin
			// same keys held, modifiers only
		end else if (kind < 90) begin
			foreach (s[i])
				s[i] = random_code();
		end else begin
			foreach (s[i])
				s[i] = 8'($urandom_range(0, 255));
		end
		queue_report(m, s, $urandom_range(0, 29) == 0);
	endtask

	// stimulus and end of run
	initial begin
		queue_report(8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0);
		queue_report(8'h00, '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0);
		queue_report(8'h02, '{8'h04, 8'h1D, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0);
		// release translated with right shift of the releasing report
		queue_report(8'h20, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1);
		queue_report(8'h22, '{8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23}, 1'b0);
		queue_report(8'h00, '{8'h24, 8'h25, 8'h26, 8'h27, 8'h1E, 8'h1F}, 1'b0);
		// six releases then six presses
		queue_report(8'hDD, '{8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h58}, 1'b0);
		queue_report(8'h00, '{8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h31, 8'h32}, 1'b0);
		queue_report(8'h02, '{8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38}, 1'b0);
		queue_report(8'h00, '{8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38}, 1'b0);
		queue_report(8'hFF, '{8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F}, 1'b0);
		queue_report(8'h00, '{8'h50, 8'h51, 8'h52, 8'h00, 8'h01, 8'hFF}, 1'b0);
		// repeated codes give one event per slot
		queue_report(8'h00, '{8'h04, 8'h04, 8'h05, 8'h05, 8'h01, 8'h00}, 1'b0);
		queue_report(8'h00, '{8'h04, 8'h04, 8'h05, 8'h05, 8'h01, 8'h00}, 1'b0);
		queue_report(8'hFF, '{8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01}, 1'b0);
		queue_report(8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0);
		// unmapped codes only
		queue_report(8'h00, '{8'hFF, 8'hFE, 8'h80, 8'h7F, 8'h39, 8'h03}, 1'b1);
		queue_report(8'h80, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
		queue_report(8'h20, '{8'h1D, 8'h27, 8'h00, 8'h58, 8'h52, 8'h4A}, 1'b0);
		queue_report(8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0);
		repeat (RANDOM_ITEMS)
			queue_random_report();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_reports.size() != 0 || push || expected_keys.size() != 0);
		repeat (SETTLE) @(negedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// report driver
	always @(posedge clk) begin : driver
		report_t nxt;
		logic    nxt_push;
		nxt_push = push;
		if (arst_n) begin
			if (push && !full) begin
				predict_key_events(offered_report);
				reports_taken++;
				nxt_push = 1'b0;
			end
			if (!nxt_push) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_reports.size() != 0 &&
					!(pending_reports[0].drain && expected_keys.size() != 0)) begin
					nxt = pending_reports.pop_front();
					offered_report = nxt;
					modifiers <= nxt.mods;
					slot_a <= nxt.codes[0];
					slot_b <= nxt.codes[1];
					slot_c <= nxt.codes[2];
					slot_d <= nxt.codes[3];
					slot_e <= nxt.codes[4];
					slot_f <= nxt.codes[5];
					nxt_push = 1'b1;
					// every so often a run of back-to-back reports
					send_gap = (reports_taken % 40 < 10) ? 0 : idle_length();
				end
			end
		end
		push <= nxt_push;
	end

	// event monitor and checker
	always @(posedge clk) begin : monitor
		key_event_t want;
		logic       nxt_pop;
		nxt_pop = pop;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_keys.size() == 0) begin
					$display("%0t: unexpected key event key_value %0d is_press %0d last_event %0d",
						$time, key_value, is_press, last_event);
					fail_count++;
				end else begin
					want = expected_keys.pop_front();
					if (key_value !== want.key) begin
						$display("%0t: key_value expected %0d actual %0d",
							$time, want.key, key_value);
						fail_count++;
					end
					if (is_press !== want.press) begin
						$display("%0t: is_press expected %0d actual %0d",
							$time, want.press, is_press);
						fail_count++;
					end
					if (last_event !== want.last) begin
						$display("%0t: last_event expected %0d actual %0d",
							$time, want.last, last_event);
						fail_count++;
					end
				end
				keys_taken++;
				if (keys_taken == LONG_HOLD_AT)
					take_hold = LONG_HOLD;
				else
					take_hold = (keys_taken % 50 < 12) ? 0 : idle_length();
			end
			if (take_hold > 0) begin
				take_hold--;
				nxt_pop = 1'b0;
			end else begin
				nxt_pop = 1'b1;
			end
		end
		pop <= nxt_pop;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
rtl/hkred_pkg.sv
rtl/hkred_front.sv
rtl/hkred_queue.sv
rtl/hkred_back.sv
rtl/hid_keyboard_report_edge_decoder_unit.sv
bench/hid_keyboard_report_edge_decoder_unit_test.sv
